[hdl/sha256_pkg.sv]
`default_nettype none
package sha256_pkg;

  localparam logic [1:0] FUNC_ABSORB = 2'd0;
  localparam logic [1:0] FUNC_ABSORB_FINISH = 2'd1;
  localparam logic [1:0] FUNC_FINISH = 2'd2;

  // Controller commands to the datapath.
  typedef struct packed {
    logic load_byte;    // write in_byte at fill position
    logic pad_byte;     // write pad byte at fill position (0x80 / 0 / length)
    logic start_comp;   // begin a compression of the block buffer
    logic chain_init;   // restore initial hash, clear counters
    logic out_shift;    // advance digest output word
  } sha_cmd_t;

  typedef struct packed {
    logic       comp_busy;
    logic       comp_done;
    logic [5:0] fill;   // bytes held in buffer
  } sha_stat_t;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] LEN_POS = 6'd56;

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    ror = (x >> n) | (x << (32 - n));
  endfunction

endpackage
`default_nettype wire

[hdl/sha256_dp.sv]
`default_nettype none
module sha256_dp (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire sha256_pkg::sha_cmd_t cmd,
  input  wire logic [7:0]           in_byte,
  output sha256_pkg::sha_stat_t     stat,
  output logic [31:0]               digest_word,
  output logic [2:0]                word_index
);

  // Block buffer held as 16 big-endian words shifted in byte by byte.
  logic [31:0] w_r [16];
  logic [5:0]  fill_r;
  logic [63:0] bits_r;
  logic [31:0] h_r [8];
  logic [31:0] v_r [8];
  logic [6:0]  rnd_r;
  logic        busy_r;
  logic        done_r;
  logic [2:0]  oidx_r;
  logic        pad_first_r;
  logic        lenok_r;
  logic [63:0] len_r;
  logic [7:0]  pad_val;
  logic [63:0] total;
  logic [31:0] s0, s1, w_new, t1, t2, wcur;
  logic [31:0] e, a;

  assign total = bits_r + {55'd0, fill_r, 3'd0};

  // Padding byte chosen from fill position: length bytes from 56 up, but only
  // in the block that carries the length.
  always_comb begin
    pad_val = 8'd0;
    if (lenok_r && fill_r >= sha256_pkg::LEN_POS)
      pad_val = len_r[{~fill_r[2:0], 3'b000} +: 8];
  end

  // Message schedule: w_r is a 16-deep shift line; w[0] is the current word.
  assign wcur  = w_r[0];
  assign s0    = sha256_pkg::ror(w_r[1], 7) ^ sha256_pkg::ror(w_r[1], 18) ^ (w_r[1] >> 3);
  assign s1    = sha256_pkg::ror(w_r[14], 17) ^ sha256_pkg::ror(w_r[14], 19)
               ^ (w_r[14] >> 10);
  assign w_new = w_r[0] + s0 + w_r[9] + s1;

  assign e  = v_r[4];
  assign a  = v_r[0];
  assign t1 = v_r[7] + (sha256_pkg::ror(e, 6) ^ sha256_pkg::ror(e, 11) ^ sha256_pkg::ror(e, 25))
            + ((e & v_r[5]) ^ (~e & v_r[6])) + sha256_pkg::ROUND_K[rnd_r[5:0]] + wcur;
  assign t2 = (sha256_pkg::ror(a, 2) ^ sha256_pkg::ror(a, 13) ^ sha256_pkg::ror(a, 22))
            + ((a & v_r[1]) ^ (a & v_r[2]) ^ (v_r[1] & v_r[2]));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      fill_r <= '0;
      bits_r <= '0;
      rnd_r  <= '0;
      oidx_r <= '0;
      for (int i = 0; i < 8; i++) h_r[i] <= sha256_pkg::INIT_H[i];
    end else begin
      done_r <= 1'b0;
      if (cmd.load_byte || cmd.pad_byte) begin
        w_r[fill_r[5:2]] <= {w_r[fill_r[5:2]][23:0],
                             cmd.load_byte ? in_byte :
                             (pad_first_r ? sha256_pkg::PAD_MARK : pad_val)};
        fill_r <= fill_r + 6'd1;
        if (cmd.load_byte && fill_r == 6'd63) bits_r <= bits_r + 64'd512;
      end
      if (cmd.start_comp) begin
        busy_r <= 1'b1;
        rnd_r  <= '0;
        for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
      end else if (busy_r) begin
        for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
        w_r[15] <= w_new;
        v_r[7] <= v_r[6];
        v_r[6] <= v_r[5];
        v_r[5] <= e;
        v_r[4] <= v_r[3] + t1;
        v_r[3] <= v_r[2];
        v_r[2] <= v_r[1];
        v_r[1] <= a;
        v_r[0] <= t1 + t2;
        rnd_r  <= rnd_r + 7'd1;
        if (rnd_r == 7'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
      if (done_r) begin
        for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
      end
      if (cmd.out_shift) oidx_r <= oidx_r + 3'd1;
      if (cmd.chain_init) begin
        for (int i = 0; i < 8; i++) h_r[i] <= sha256_pkg::INIT_H[i];
        fill_r <= '0;
        bits_r <= '0;
        oidx_r <= '0;
      end
    end
  end

  // The first pad byte of a finish is the 0x80 marker; the message length is
  // captured at that byte. A pad byte below the length field marks the block
  // that carries the length.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pad_first_r <= 1'b1;
      lenok_r     <= 1'b0;
      len_r       <= '0;
    end else if (cmd.chain_init) begin
      pad_first_r <= 1'b1;
      lenok_r     <= 1'b0;
    end else if (cmd.pad_byte) begin
      pad_first_r <= 1'b0;
      if (pad_first_r) len_r <= total;
      if (fill_r < sha256_pkg::LEN_POS) lenok_r <= 1'b1;
    end
  end

  assign stat.comp_busy = busy_r;
  assign stat.comp_done = done_r;
  assign stat.fill      = fill_r;
  assign digest_word    = h_r[oidx_r];
  assign word_index     = oidx_r;

  ap_round_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> rnd_r < 7'd64) else $error("round counter overrun");
  ap_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("done while busy");
  ap_done_after: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("done without compression");

endmodule
`default_nettype wire

[hdl/sha256_ctrl.sv]
`default_nettype none
module sha256_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [1:0]            in_func,
  input  wire sha256_pkg::sha_stat_t stat,
  output sha256_pkg::sha_cmd_t       cmd,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  input  wire logic [2:0]            word_index
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_ABS   = 6'b000010,
    S_PAD   = 6'b000100,
    S_PCOMP = 6'b001000,
    S_FINAL = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   fin_r, fin_nxt;
  logic   accept;
  logic   lenblk_r;

  assign accept = in_tvalid && in_tready;

  always_comb begin
    state_nxt  = state_r;
    fin_nxt    = fin_r;
    cmd        = '0;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = !stat.comp_busy && !stat.comp_done;
        if (accept) begin
          case (in_func) inside
            sha256_pkg::FUNC_ABSORB, sha256_pkg::FUNC_ABSORB_FINISH: begin
              cmd.load_byte = 1'b1;
              fin_nxt = (in_func == sha256_pkg::FUNC_ABSORB_FINISH);
              if (stat.fill == 6'd63) begin
                cmd.start_comp = 1'b1;
                state_nxt = S_ABS;
              end else if (in_func == sha256_pkg::FUNC_ABSORB_FINISH) begin
                state_nxt = S_PAD;
              end
            end
            sha256_pkg::FUNC_FINISH: state_nxt = S_PAD;
            default: ;
          endcase
        end
      end
      S_ABS: if (stat.comp_done) state_nxt = fin_r ? S_PAD : S_IDLE;
      S_PAD: begin
        if (!stat.comp_busy && !stat.comp_done) begin
          cmd.pad_byte = 1'b1;
          if (stat.fill == 6'd63) begin
            cmd.start_comp = 1'b1;
            state_nxt = S_PCOMP;
          end
        end
      end
      S_PCOMP: if (stat.comp_done) state_nxt = S_FINAL;
      S_FINAL: begin
        // Once the length block is hashed the digest is ready; otherwise the
        // second padding block follows.
        state_nxt = lenblk_r ? S_OUT : S_PAD;
      end
      S_OUT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          cmd.out_shift = 1'b1;
          if (word_index == 3'd7) begin
            cmd.chain_init = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // lenblk_r is set once a pad byte lands below the length field, which marks
  // the block that carries the length.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      fin_r    <= 1'b0;
      lenblk_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fin_r   <= fin_nxt;
      if (state_r == S_IDLE) lenblk_r <= 1'b0;
      else if (state_r == S_PAD && cmd.pad_byte && stat.fill < sha256_pkg::LEN_POS)
        lenblk_r <= 1'b1;
    end
  end

  ap_out_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> state_r == S_OUT) else $error("output outside S_OUT");
  ap_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !stat.comp_busy) else $error("ready while compressing");
  ap_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r)) else $error("state not one-hot");

endmodule
`default_nettype wire

[hdl/sha256_hash_engine.sv]
`default_nettype none
// Each accepted byte is loaded into the block buffer; the 64th byte of a block also starts its rounds.
// A finish adds one pad byte per cycle plus the rounds of each padding block (one or two),
// then eight digest items, one per cycle while out_tready is high.
// No byte is taken while the one-round-per-cycle compression unit works on a block.
// Reset (rst_n low, synchronous) restores the initial hash, clears counts and drops out_tvalid.
module sha256_hash_engine (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic [1:0]  in_tuser,   // [1:0] func
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [31:0] digest_word
  output logic [2:0]       out_tuser,  // [2:0] word_index
  output logic             out_tlast   // last_word
);

  sha256_pkg::sha_cmd_t  cmd;
  sha256_pkg::sha_stat_t stat;
  logic [2:0]            widx;

  // The controller sequences byte loading, padding and output; the datapath
  // holds the block buffer, schedule, round unit and chaining value.
  sha256_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_func    (in_tuser),
    .stat       (stat),
    .cmd        (cmd),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .word_index (widx)
  );

  sha256_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_byte     (in_tdata),
    .stat        (stat),
    .digest_word (out_tdata),
    .word_index  (widx)
  );

  assign out_tuser = widx;
  assign out_tlast = (widx == 3'd7);

endmodule
`default_nettype wire

[dv/testbench.sv]
`default_nettype none
module testbench;

  // Code with no defined action; the block must ignore it.
  localparam logic [1:0] FUNC_IDLE_CODE = 2'd3;
  localparam int STALL_LIMIT = 20000;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_entry_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  // Predicted hash state.
  logic [31:0] hash_words[8];
  logic [7:0]  block_bytes[64];
  int          block_fill;
  logic [63:0] done_bits;

  digest_entry_t digest_queue[$];
  int  error_count = 0;
  int  items_sent = 0;
  int  stall_cycles = 0;
  bit  no_gaps = 1'b0;
  bit  hold_output = 1'b0;

  sha256_hash_engine dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  always #5 clk = ~clk;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    logic [63:0] twice;
    twice = {x, x} >> n;
    return twice[31:0];
  endfunction

  function automatic void clear_hash();
    for (int i = 0; i < 8; i++) hash_words[i] = sha256_pkg::INIT_H[i];
    block_fill = 0;
    done_bits = '0;
  endfunction

  // One 64-round compression of the block bytes into the hash words.
  function automatic void compress_block();
    logic [31:0] w[64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
    for (int i = 0; i < 16; i++)
      w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2], block_bytes[4*i+3]};
    for (int i = 16; i < 64; i++) begin
      s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    {a, b, c, d, e, f, g, h} = {hash_words[0], hash_words[1], hash_words[2], hash_words[3],
                                hash_words[4], hash_words[5], hash_words[6], hash_words[7]};
    for (int i = 0; i < 64; i++) begin
      t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
           + sha256_pkg::ROUND_K[i] + w[i];
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    hash_words[0] += a; hash_words[1] += b; hash_words[2] += c; hash_words[3] += d;
    hash_words[4] += e; hash_words[5] += f; hash_words[6] += g; hash_words[7] += h;
  endfunction

  function automatic void absorb(input logic [7:0] b);
    block_bytes[block_fill] = b;
    block_fill++;
    if (block_fill == 64) begin
      compress_block();
      done_bits += 64'd512;
      block_fill = 0;
    end
  endfunction

  // Pads the message, queues the eight digest words and restarts the hash.
  function automatic void finish_digest();
    logic [63:0] total;
    int pos;
    digest_entry_t entry;
    total = done_bits + 64'(block_fill) * 8;
    pos = block_fill;
    block_bytes[pos] = sha256_pkg::PAD_MARK;
    pos++;
    if (pos > 56) begin
      while (pos < 64) begin
        block_bytes[pos] = 8'h00;
        pos++;
      end
      compress_block();
      pos = 0;
    end
    while (pos < 56) begin
      block_bytes[pos] = 8'h00;
      pos++;
    end
    for (int i = 0; i < 8; i++) block_bytes[63-i] = total[8*i +: 8];
    compress_block();
    for (int i = 0; i < 8; i++) begin
      entry.word = hash_words[i];
      entry.index = 3'(i);
      entry.last = (i == 7);
      digest_queue.push_back(entry);
    end
    clear_hash();
  endfunction

  function automatic void predict_item(input logic [1:0] f, input logic [7:0] b);
    case (f)
      sha256_pkg::FUNC_ABSORB: begin
        absorb(b);
      end
      sha256_pkg::FUNC_ABSORB_FINISH: begin
        absorb(b);
        finish_digest();
      end
      sha256_pkg::FUNC_FINISH: begin
        finish_digest();
      end
      default: begin
      end
    endcase
  endfunction

  // Offers one item, with an occasional random gap first, and waits for the handshake.
  task automatic send_item(input logic [1:0] f, input logic [7:0] b);
    if (!no_gaps && $urandom_range(99) < 9) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser = f;
    in_tdata = b;
    do @(posedge clk); while (!in_tready);
    predict_item(f, b);
    items_sent++;
    @(negedge clk);
  endtask

  // A whole message of random bytes; the last byte sometimes carries the finish.
  task automatic send_message(input int len);
    bit merged;
    merged = (len > 0) && $urandom_range(1);
    for (int i = 0; i < len; i++)
      send_item((merged && i == len - 1) ? sha256_pkg::FUNC_ABSORB_FINISH :
                sha256_pkg::FUNC_ABSORB, 8'($urandom_range(255)));
    if (!merged) send_item(sha256_pkg::FUNC_FINISH, 8'($urandom_range(255)));
  endtask

  // Empty message, all-zero and all-one bytes, and the undefined code.
  task automatic test_directed();
    send_item(sha256_pkg::FUNC_FINISH, 8'h00);
    send_item(FUNC_IDLE_CODE, 8'hff);
    send_item(sha256_pkg::FUNC_FINISH, 8'hff);
    send_item(sha256_pkg::FUNC_ABSORB_FINISH, 8'h00);
    send_item(sha256_pkg::FUNC_ABSORB, 8'hff);
    send_item(FUNC_IDLE_CODE, 8'h5a);
    send_item(sha256_pkg::FUNC_ABSORB, 8'h00);
    send_item(sha256_pkg::FUNC_ABSORB_FINISH, 8'hff);
    send_item(sha256_pkg::FUNC_ABSORB, 8'ha5);
    send_item(sha256_pkg::FUNC_FINISH, 8'h3c);
  endtask

  // Message lengths around the padding and block boundaries, both with and without gaps.
  task automatic test_boundaries();
    int lens[5] = '{55, 56, 63, 64, 119};
    foreach (lens[i]) begin
      no_gaps = (i >= 3);
      send_message(lens[i]);
    end
    no_gaps = 1'b0;
  endtask

  // The receiver holds off while the sender keeps offering the next message.
  task automatic test_output_backpressure();
    fork
      begin
        send_message(3);
        send_message(70);
      end
      begin
        hold_output = 1'b1;
        repeat (300) @(posedge clk);
        hold_output = 1'b0;
      end
    join
  endtask

  // Mostly short well-formed messages with random content, some noise codes mixed in.
  task automatic test_random();
    int len;
    while (items_sent < 480) begin
      if ($urandom_range(99) < 8) begin
        send_item(FUNC_IDLE_CODE, 8'($urandom_range(255)));
      end else begin
        len = ($urandom_range(9) == 0) ? $urandom_range(50, 130) : $urandom_range(0, 20);
        if (len > 480 - items_sent) len = 480 - items_sent;
        send_message(len);
      end
    end
  endtask

  // Receiver readiness, changed only at the falling edge.
  always @(negedge clk) begin
    if (hold_output) out_tready <= 1'b0;
    else if (no_gaps) out_tready <= 1'b1;
    else out_tready <= ($urandom_range(99) >= 9);
  end

  // Digest checker: every accepted word against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (digest_queue.size() == 0) begin
        $display("%0t: digest word %h arrived with none expected", $time, out_tdata);
        error_count++;
      end else begin
        if (out_tdata !== digest_queue[0].word) begin
          $display("%0t: digest_word expected %h actual %h", $time,
                   digest_queue[0].word, out_tdata);
          error_count++;
        end
        if (out_tuser !== digest_queue[0].index) begin
          $display("%0t: word_index expected %0d actual %0d", $time,
                   digest_queue[0].index, out_tuser);
          error_count++;
        end
        if (out_tlast !== digest_queue[0].last) begin
          $display("%0t: last_word expected %b actual %b", $time,
                   digest_queue[0].last, out_tlast);
          error_count++;
        end
        void'(digest_queue.pop_front());
      end
    end
  end

  // Watchdog on cycles in which neither side moves an item.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    clear_hash();
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_boundaries();
    test_output_backpressure();
    test_random();
    in_tvalid = 1'b0;
    while (digest_queue.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
`default_nettype wire
